/* hw/rtl/abdt_pkg.sv */
// Shared types, constants and table functions of the anchor box decoder.
`default_nettype none

package abdt_pkg;

   // Field widths.
   localparam int CLASS_W = 7;
   localparam int SCORE_W = 16;
   localparam int LOGIT_W = 16;
   localparam int COORD_W = 13;
   localparam int NSIZE_W = 12;
   localparam int CSR_W   = 16;

   // Fixed-point widths of the box arithmetic (Q.16 and Q.32 pixel positions).
   localparam int CQ16_W  = 31;
   localparam int POS_W   = 48;
   localparam int HALF_W  = 42;
   localparam int MAG_W   = 44;
   localparam int NUM_W   = 25;
   localparam int DIV_STEPS = 13;

   // Number of detection heads and anchors per head.
   localparam logic [1:0] LEVEL_COUNT  = 2'd3;
   localparam logic [1:0] ANCHOR_COUNT = 2'd3;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SCORE_THRESHOLD,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_NETWORK_SIZE
   } abdt_csr_type;

   // Centre and half size of a box, with class and score.
   typedef struct packed {
      logic [CLASS_W-1:0]      class_id;
      logic [SCORE_W-1:0]      score;
      logic signed [POS_W-1:0] cx;
      logic signed [POS_W-1:0] cy;
      logic [HALF_W-1:0]       hw;
      logic [HALF_W-1:0]       hh;
   } abdt_box_type;

   // One corner ready for division: below zero, beyond the image, or a numerator.
   typedef struct packed {
      logic             lo;
      logic             hi;
      logic [NUM_W-1:0] num;
   } abdt_lane_type;

   typedef struct packed {
      logic [CLASS_W-1:0]      class_id;
      logic [SCORE_W-1:0]      score;
      abdt_lane_type [3:0]     lane;
   } abdt_corner_type;

   // One corner in the middle of the long division.
   typedef struct packed {
      logic               lo;
      logic               hi;
      logic [NUM_W-1:0]   num;
      logic [NSIZE_W-1:0] rem;
      logic [COORD_W-1:0] quot;
   } abdt_dlane_type;

   typedef struct packed {
      logic [CLASS_W-1:0]   class_id;
      logic [SCORE_W-1:0]   score;
      abdt_dlane_type [3:0] lane;
   } abdt_div_type;

   // Sigmoid knots at steps of 0.5 in Q0.16.
   function automatic logic [15:0] abdt_sig_knot(input logic [4:0] k);
      logic [15:0] v;
      case (k)
         5'd0:    v = 16'd32768;
         5'd1:    v = 16'd40793;
         5'd2:    v = 16'd47911;
         5'd3:    v = 16'd53581;
         5'd4:    v = 16'd57724;
         5'd5:    v = 16'd60565;
         5'd6:    v = 16'd62428;
         5'd7:    v = 16'd63615;
         5'd8:    v = 16'd64357;
         5'd9:    v = 16'd64816;
         5'd10:   v = 16'd65097;
         5'd11:   v = 16'd65269;
         5'd12:   v = 16'd65374;
         5'd13:   v = 16'd65438;
         5'd14:   v = 16'd65476;
         5'd15:   v = 16'd65500;
         default: v = 16'd65514;
      endcase
      return v;
   endfunction

   // Piecewise linear sigmoid of a signed Q8.8 logit, result in Q0.16.
   function automatic logic [15:0] abdt_sigmoid(input logic [15:0] raw);
      logic        neg;
      logic [15:0] mag;
      logic [3:0]  idx;
      logic [6:0]  frac;
      logic [15:0] t0;
      logic [15:0] t1;
      logic [19:0] prod;
      logic [16:0] s;
      logic [16:0] res;
      neg  = raw[15];
      mag  = neg ? 16'(~raw + 16'd1) : raw;
      idx  = mag[10:7];
      frac = mag[6:0];
      t0   = abdt_sig_knot({1'b0, idx});
      t1   = abdt_sig_knot(5'({1'b0, idx} + 5'd1));
      prod = 20'(t1 - t0) * 20'(frac) + 20'd64;
      if (mag >= 16'd2048) begin
         s = 17'(abdt_sig_knot(5'd16));
      end else begin
         s = 17'(t0) + 17'(prod[19:7]);
      end
      res = neg ? 17'(17'h10000 - s) : s;
      return res[15:0];
   endfunction

   // Left shift that multiplies by the head's stride.
   function automatic logic [2:0] abdt_stride_shift(input logic [1:0] level);
      logic [2:0] v;
      case (level)
         2'd0:    v = 3'd3;
         2'd1:    v = 3'd4;
         2'd2:    v = 3'd5;
         default: v = 3'd6;
      endcase
      return v;
   endfunction

   // Anchor width in pixels.
   function automatic logic [8:0] abdt_anchor_w(input logic [1:0] level,
                                                input logic [1:0] slot);
      logic [8:0] v;
      case ({level, slot})
         4'h0:    v = 9'd10;
         4'h1:    v = 9'd16;
         4'h2:    v = 9'd33;
         4'h4:    v = 9'd30;
         4'h5:    v = 9'd62;
         4'h6:    v = 9'd59;
         4'h8:    v = 9'd116;
         4'h9:    v = 9'd156;
         4'hA:    v = 9'd373;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Anchor height in pixels.
   function automatic logic [8:0] abdt_anchor_h(input logic [1:0] level,
                                                input logic [1:0] slot);
      logic [8:0] v;
      case ({level, slot})
         4'h0:    v = 9'd13;
         4'h1:    v = 9'd30;
         4'h2:    v = 9'd23;
         4'h4:    v = 9'd61;
         4'h5:    v = 9'd45;
         4'h6:    v = 9'd119;
         4'h8:    v = 9'd90;
         4'h9:    v = 9'd198;
         4'hA:    v = 9'd326;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/abdt_score_box.sv */
// Three pipeline stages: sigmoids, score and box centre, threshold and half size.
`default_nettype none

module abdt_score_box
   import abdt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [1:0]           scale_level,
   input  wire logic [1:0]           anchor_slot,
   input  wire logic [7:0]           grid_col,
   input  wire logic [7:0]           grid_row,
   input  wire logic [LOGIT_W-1:0]   logit_x,
   input  wire logic [LOGIT_W-1:0]   logit_y,
   input  wire logic [LOGIT_W-1:0]   logit_w,
   input  wire logic [LOGIT_W-1:0]   logit_h,
   input  wire logic [LOGIT_W-1:0]   logit_obj,
   input  wire logic [CLASS_W-1:0]   class_index,
   input  wire logic [LOGIT_W-1:0]   logit_class,
   input  wire logic [SCORE_W-1:0]   score_threshold,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output abdt_box_type              out_box
);

   // Stage one registers: sigmoid values and cell position.
   logic                s1_v_ff;
   logic [15:0]         s1_sx_ff, s1_sy_ff, s1_sw_ff, s1_sh_ff, s1_so_ff, s1_sc_ff;
   logic [1:0]          s1_level_ff, s1_slot_ff;
   logic [7:0]          s1_col_ff, s1_row_ff;
   logic [CLASS_W-1:0]  s1_class_ff;

   // Stage two registers: score, squared sizes and centre in Q.16.
   logic                     s2_v_ff;
   logic [SCORE_W-1:0]       s2_score_ff;
   logic [31:0]              s2_sqw_ff, s2_sqh_ff;
   logic signed [CQ16_W-1:0] s2_cx_ff, s2_cy_ff;
   logic [8:0]               s2_aw_ff, s2_ah_ff;
   logic [CLASS_W-1:0]       s2_class_ff;

   // Stage three registers: the box.
   logic         s3_v_ff;
   abdt_box_type s3_box_ff;

   logic s1_ready, s2_ready, s3_ready;
   logic s1_v_in, s3_v_in;

   // A stage takes new data when it is empty or its content moves on.
   assign s3_ready = !s3_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   // Candidates of an unknown head or anchor are dropped at once; every 7-bit
   // class number is in range.
   assign s1_v_in = in_valid && (scale_level < LEVEL_COUNT) && (anchor_slot < ANCHOR_COUNT);

   // Stage two combinational work.
   logic [31:0]              score_prod;
   logic signed [25:0]       cx_base, cy_base;
   logic signed [CQ16_W-1:0] cx_wide, cy_wide;
   logic [2:0]               shamt;

   always_comb begin
      score_prod = 32'(s1_sc_ff) * 32'(s1_so_ff);
      cx_base    = $signed({2'b00, s1_col_ff, 16'h0000}) + $signed({9'd0, s1_sx_ff, 1'b0})
                   - 26'sd32768;
      cy_base    = $signed({2'b00, s1_row_ff, 16'h0000}) + $signed({9'd0, s1_sy_ff, 1'b0})
                   - 26'sd32768;
      cx_wide    = {{(CQ16_W-26){cx_base[25]}}, cx_base};
      cy_wide    = {{(CQ16_W-26){cy_base[25]}}, cy_base};
      shamt      = abdt_stride_shift(s1_level_ff);
   end

   // Stage three combinational work.
   logic [40:0] hw_prod, hh_prod;

   always_comb begin
      hw_prod = 41'(s2_sqw_ff) * 41'(s2_aw_ff);
      hh_prod = 41'(s2_sqh_ff) * 41'(s2_ah_ff);
      s3_v_in = s2_v_ff && (s2_score_ff > score_threshold);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= s1_v_in;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s3_v_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_sx_ff    <= abdt_sigmoid(logit_x);
         s1_sy_ff    <= abdt_sigmoid(logit_y);
         s1_sw_ff    <= abdt_sigmoid(logit_w);
         s1_sh_ff    <= abdt_sigmoid(logit_h);
         s1_so_ff    <= abdt_sigmoid(logit_obj);
         s1_sc_ff    <= abdt_sigmoid(logit_class);
         s1_level_ff <= scale_level;
         s1_slot_ff  <= anchor_slot;
         s1_col_ff   <= grid_col;
         s1_row_ff   <= grid_row;
         s1_class_ff <= class_index;
      end
      if (s2_ready) begin
         s2_score_ff <= score_prod[31:16];
         s2_sqw_ff   <= 32'(s1_sw_ff) * 32'(s1_sw_ff);
         s2_sqh_ff   <= 32'(s1_sh_ff) * 32'(s1_sh_ff);
         s2_cx_ff    <= cx_wide <<< shamt;
         s2_cy_ff    <= cy_wide <<< shamt;
         s2_aw_ff    <= abdt_anchor_w(s1_level_ff, s1_slot_ff);
         s2_ah_ff    <= abdt_anchor_h(s1_level_ff, s1_slot_ff);
         s2_class_ff <= s1_class_ff;
      end
      if (s3_ready) begin
         s3_box_ff.class_id <= s2_class_ff;
         s3_box_ff.score    <= s2_score_ff;
         s3_box_ff.cx       <= {s2_cx_ff[CQ16_W-1], s2_cx_ff, 16'h0000};
         s3_box_ff.cy       <= {s2_cy_ff[CQ16_W-1], s2_cy_ff, 16'h0000};
         s3_box_ff.hw       <= {hw_prod, 1'b0};
         s3_box_ff.hh       <= {hh_prod, 1'b0};
      end
   end

   assign out_valid = s3_v_ff;
   assign out_box   = s3_box_ff;

endmodule

`default_nettype wire

/* hw/rtl/abdt_corner.sv */
// Three pipeline stages: corners, range checks and scaling by the image size.
`default_nettype none

module abdt_corner
   import abdt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire abdt_box_type       in_box,
   input  wire logic [NSIZE_W-1:0] divisor,
   input  wire logic [COORD_W-1:0] image_width,
   input  wire logic [COORD_W-1:0] image_height,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output abdt_corner_type         out_corner
);

   // Lanes: 0 left, 1 top, 2 right, 3 bottom.
   logic                    c1_v_ff;
   logic signed [POS_W-1:0] c1_pos_ff [4];
   logic [CLASS_W-1:0]      c1_class_ff;
   logic [SCORE_W-1:0]      c1_score_ff;

   logic                    c2_v_ff;
   logic [3:0]              c2_lo_ff, c2_hi_ff;
   logic [MAG_W-1:0]        c2_mag_ff [4];
   logic [CLASS_W-1:0]      c2_class_ff;
   logic [SCORE_W-1:0]      c2_score_ff;

   logic                    c3_v_ff;
   abdt_corner_type         c3_ff;

   logic c1_ready, c2_ready, c3_ready;

   assign c3_ready = !c3_v_ff || out_ready;
   assign c2_ready = !c2_v_ff || c3_ready;
   assign c1_ready = !c1_v_ff || c2_ready;
   assign in_ready = c1_ready;

   // Corners in Q.32 pixels of the network input.
   logic signed [POS_W-1:0] pos_in [4];
   always_comb begin
      pos_in[0] = in_box.cx - $signed({{(POS_W-HALF_W){1'b0}}, in_box.hw});
      pos_in[1] = in_box.cy - $signed({{(POS_W-HALF_W){1'b0}}, in_box.hh});
      pos_in[2] = in_box.cx + $signed({{(POS_W-HALF_W){1'b0}}, in_box.hw});
      pos_in[3] = in_box.cy + $signed({{(POS_W-HALF_W){1'b0}}, in_box.hh});
   end

   // A corner at or below zero maps to zero; one at or past the network edge maps
   // to the image edge; only the rest needs the division.
   logic [POS_W-1:0] edge_limit;
   logic [3:0]       lo_in, hi_in;
   always_comb begin
      edge_limit = {{(POS_W-NSIZE_W-32){1'b0}}, divisor, 32'h0};
      for (int l = 0; l < 4; l++) begin
         lo_in[l] = c1_pos_ff[l][POS_W-1] || (c1_pos_ff[l] == '0);
         hi_in[l] = !c1_pos_ff[l][POS_W-1] && (unsigned'(c1_pos_ff[l]) >= edge_limit);
      end
   end

   // Numerator of the division: corner times image size, whole pixels.
   logic [MAG_W+COORD_W-1:0] prod_in [4];
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         prod_in[l] = (MAG_W+COORD_W)'(c2_mag_ff[l])
                      * (MAG_W+COORD_W)'((l % 2 == 0) ? image_width : image_height);
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
      end else begin
         if (c1_ready) begin
            c1_v_ff <= in_valid;
         end
         if (c2_ready) begin
            c2_v_ff <= c1_v_ff;
         end
         if (c3_ready) begin
            c3_v_ff <= c2_v_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (c1_ready) begin
         c1_pos_ff   <= pos_in;
         c1_class_ff <= in_box.class_id;
         c1_score_ff <= in_box.score;
      end
      if (c2_ready) begin
         c2_lo_ff    <= lo_in;
         c2_hi_ff    <= hi_in;
         for (int l = 0; l < 4; l++) begin
            c2_mag_ff[l] <= MAG_W'(c1_pos_ff[l]);
         end
         c2_class_ff <= c1_class_ff;
         c2_score_ff <= c1_score_ff;
      end
      if (c3_ready) begin
         c3_ff.class_id <= c2_class_ff;
         c3_ff.score    <= c2_score_ff;
         for (int l = 0; l < 4; l++) begin
            c3_ff.lane[l].lo  <= c2_lo_ff[l];
            c3_ff.lane[l].hi  <= c2_hi_ff[l];
            c3_ff.lane[l].num <= prod_in[l][MAG_W+COORD_W-1:32];
         end
      end
   end

   assign out_valid  = c3_v_ff;
   assign out_corner = c3_ff;

endmodule

`default_nettype wire

/* hw/rtl/abdt_divider.sv */
// Pipelined restoring divider, one quotient bit per stage for four corners,
// followed by the clamp and the result register.
`default_nettype none

module abdt_divider
   import abdt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire abdt_corner_type    in_corner,
   input  wire logic [NSIZE_W-1:0] divisor,
   input  wire logic [COORD_W-1:0] image_width,
   input  wire logic [COORD_W-1:0] image_height,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [CLASS_W-1:0]      out_class_id,
   output logic [SCORE_W-1:0]      out_score,
   output logic [COORD_W-1:0]      out_left,
   output logic [COORD_W-1:0]      out_top,
   output logic [COORD_W-1:0]      out_right,
   output logic [COORD_W-1:0]      out_bottom
);

   logic         dv_v_ff [DIV_STEPS];
   abdt_div_type dv_ff   [DIV_STEPS];
   logic         dv_ready [DIV_STEPS+1];

   logic                out_v_ff;
   logic [CLASS_W-1:0]  out_class_ff;
   logic [SCORE_W-1:0]  out_score_ff;
   logic [COORD_W-1:0]  out_pos_ff [4];

   assign dv_ready[DIV_STEPS] = !out_v_ff || out_ready;
   assign in_ready            = dv_ready[0];

   // The quotient is below the image size, so its upper bits are zero and the
   // division starts with the numerator's upper bits as remainder.
   abdt_div_type first;
   always_comb begin
      first.class_id = in_corner.class_id;
      first.score    = in_corner.score;
      for (int l = 0; l < 4; l++) begin
         first.lane[l].lo   = in_corner.lane[l].lo;
         first.lane[l].hi   = in_corner.lane[l].hi;
         first.lane[l].num  = in_corner.lane[l].num;
         first.lane[l].rem  = in_corner.lane[l].num[NUM_W-1:DIV_STEPS];
         first.lane[l].quot = '0;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BitPos = DIV_STEPS - 1 - k;
      abdt_div_type          src;
      logic                  src_v;
      abdt_div_type          step_in;
      logic [NSIZE_W:0]      trial [4];
      logic [3:0]            take;

      if (k == 0) begin : g_head
         assign src   = first;
         assign src_v = in_valid;
      end else begin : g_body
         assign src   = dv_ff[k-1];
         assign src_v = dv_v_ff[k-1];
      end

      assign dv_ready[k] = !dv_v_ff[k] || dv_ready[k+1];

      // One compare and subtract per corner.
      always_comb begin
         step_in = src;
         for (int l = 0; l < 4; l++) begin
            trial[l] = {src.lane[l].rem, src.lane[l].num[BitPos]};
            take[l]  = trial[l] >= {1'b0, divisor};
            step_in.lane[l].rem  = take[l] ? NSIZE_W'(trial[l] - {1'b0, divisor})
                                           : trial[l][NSIZE_W-1:0];
            step_in.lane[l].quot = {src.lane[l].quot[COORD_W-2:0], take[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (dv_ready[k]) begin
            dv_v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (dv_ready[k]) begin
            dv_ff[k] <= step_in;
         end
      end
   end

   // Clamp to the image and register the result.
   logic [COORD_W-1:0] pos_in [4];
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (dv_ff[DIV_STEPS-1].lane[l].lo) begin
            pos_in[l] = '0;
         end else if (dv_ff[DIV_STEPS-1].lane[l].hi) begin
            pos_in[l] = (l % 2 == 0) ? image_width : image_height;
         end else begin
            pos_in[l] = dv_ff[DIV_STEPS-1].lane[l].quot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (dv_ready[DIV_STEPS]) begin
         out_v_ff <= dv_v_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready[DIV_STEPS]) begin
         out_class_ff <= dv_ff[DIV_STEPS-1].class_id;
         out_score_ff <= dv_ff[DIV_STEPS-1].score;
         out_pos_ff   <= pos_in;
      end
   end

   assign out_valid    = out_v_ff;
   assign out_class_id = out_class_ff;
   assign out_score    = out_score_ff;
   assign out_left     = out_pos_ff[0];
   assign out_top      = out_pos_ff[1];
   assign out_right    = out_pos_ff[2];
   assign out_bottom   = out_pos_ff[3];

endmodule

`default_nettype wire

/* hw/rtl/anchor_box_decode_threshold.sv */
// Anchor box decoder with score threshold: top level and configuration registers.
//
// Each req_ transaction carries one class candidate of one anchor cell: head,
// anchor slot, grid cell, four box logits, objectness and class logits (Q8.8).
// The score is sigmoid(class) * sigmoid(objectness) in Q0.16. A candidate whose
// score is strictly above the threshold leaves as one rsp_ transaction with the
// class, the score and the box corners in source image pixels; any other
// candidate, or one of an unknown head or anchor slot, leaves nothing.
// Six arithmetic stages, thirteen divider stages (one quotient bit each, set by
// the 13-bit coordinate range) and the result register form the pipeline. One
// transaction is taken every cycle unless the pipeline is full. Each stage
// moves on when its successor is empty or moving, so a stall on rsp_ready fills
// the pipeline before req_ready falls, and dropped candidates leave gaps that
// later ones close up. Nothing is lost or repeated. Configuration is written
// through csr_ with one write per cycle, only while the pipeline is empty; the
// user must ensure it, as the block does not enforce it. Reset is synchronous:
// it empties the pipeline; threshold 6554, image and network sizes 640.
`default_nettype none

module anchor_box_decode_threshold
   import abdt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_scale_level,
   input  wire logic [1:0]         req_anchor_slot,
   input  wire logic [7:0]         req_grid_col,
   input  wire logic [7:0]         req_grid_row,
   input  wire logic [LOGIT_W-1:0] req_logit_x,
   input  wire logic [LOGIT_W-1:0] req_logit_y,
   input  wire logic [LOGIT_W-1:0] req_logit_w,
   input  wire logic [LOGIT_W-1:0] req_logit_h,
   input  wire logic [LOGIT_W-1:0] req_logit_obj,
   input  wire logic [CLASS_W-1:0] req_class_index,
   input  wire logic [LOGIT_W-1:0] req_logit_class,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CLASS_W-1:0]      rsp_class_id,
   output logic [SCORE_W-1:0]      rsp_score,
   output logic [COORD_W-1:0]      rsp_left,
   output logic [COORD_W-1:0]      rsp_top,
   output logic [COORD_W-1:0]      rsp_right,
   output logic [COORD_W-1:0]      rsp_bottom,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [CSR_W-1:0]   csr_write_data
);

   logic [SCORE_W-1:0] score_threshold_ff;
   logic [COORD_W-1:0] image_width_ff;
   logic [COORD_W-1:0] image_height_ff;
   logic [NSIZE_W-1:0] network_size_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         score_threshold_ff <= SCORE_W'(6554);
         image_width_ff     <= COORD_W'(640);
         image_height_ff    <= COORD_W'(640);
         network_size_ff    <= NSIZE_W'(640);
      end else if (csr_write_enable) begin
         unique case (abdt_csr_type'(csr_index))
            CSR_SCORE_THRESHOLD: score_threshold_ff <= csr_write_data[SCORE_W-1:0];
            CSR_IMAGE_WIDTH:     image_width_ff     <= csr_write_data[COORD_W-1:0];
            CSR_IMAGE_HEIGHT:    image_height_ff    <= csr_write_data[COORD_W-1:0];
            CSR_NETWORK_SIZE:    network_size_ff    <= csr_write_data[NSIZE_W-1:0];
         endcase
      end
   end

   // A network size of zero divides as one.
   logic [NSIZE_W-1:0] divisor;
   assign divisor = (network_size_ff == '0) ? NSIZE_W'(1) : network_size_ff;

   logic            box_valid, box_ready;
   abdt_box_type    box;
   logic            corner_valid, corner_ready;
   abdt_corner_type corner;

   abdt_score_box u_score_box (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .scale_level     (req_scale_level),
      .anchor_slot     (req_anchor_slot),
      .grid_col        (req_grid_col),
      .grid_row        (req_grid_row),
      .logit_x         (req_logit_x),
      .logit_y         (req_logit_y),
      .logit_w         (req_logit_w),
      .logit_h         (req_logit_h),
      .logit_obj       (req_logit_obj),
      .class_index     (req_class_index),
      .logit_class     (req_logit_class),
      .score_threshold (score_threshold_ff),
      .out_valid       (box_valid),
      .out_ready       (box_ready),
      .out_box         (box)
   );

   abdt_corner u_corner (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (box_valid),
      .in_ready     (box_ready),
      .in_box       (box),
      .divisor      (divisor),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .out_valid    (corner_valid),
      .out_ready    (corner_ready),
      .out_corner   (corner)
   );

   abdt_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (corner_valid),
      .in_ready     (corner_ready),
      .in_corner    (corner),
      .divisor      (divisor),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_class_id (rsp_class_id),
      .out_score    (rsp_score),
      .out_left     (rsp_left),
      .out_top      (rsp_top),
      .out_right    (rsp_right),
      .out_bottom   (rsp_bottom)
   );

   // The pipeline is empty after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // With the result register empty every stage can move, so input is taken.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the result register is empty");

   // Half sizes are never negative, so corners stay ordered.
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left <= rsp_right) && (rsp_top <= rsp_bottom))
      else $error("box corners out of order");

endmodule

`default_nettype wire

/* tb/tb_anchor_box_decode_threshold.sv */
// Self-checking testbench for the anchor box decoder with score threshold.
`default_nettype none

module tb_anchor_box_decode_threshold;
   import abdt_pkg::*;

   // One candidate as presented on the request channel.
   typedef struct packed {
      logic [1:0]  level;
      logic [1:0]  slot;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [15:0] lx;
      logic [15:0] ly;
      logic [15:0] lw;
      logic [15:0] lh;
      logic [15:0] lobj;
      logic [6:0]  cls;
      logic [15:0] lcls;
   } candidate_type;

   // One detection as seen on the response channel.
   typedef struct packed {
      logic [6:0]  cls;
      logic [15:0] score;
      logic [12:0] left;
      logic [12:0] top;
      logic [12:0] right;
      logic [12:0] bottom;
   } detection_type;

   localparam int LATENCY     = 20;
   localparam int STALL_LIMIT = 2000;

   logic          clock;
   logic          reset;
   logic          req_valid = 1'b0;
   logic          req_ready;
   candidate_type req_item = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [6:0]    rsp_class_id;
   logic [15:0]   rsp_score;
   logic [12:0]   rsp_left;
   logic [12:0]   rsp_top;
   logic [12:0]   rsp_right;
   logic [12:0]   rsp_bottom;
   logic          csr_write_enable;
   abdt_csr_type  csr_index;
   logic [15:0]   csr_write_data;

   // Shadow copy of the configuration registers.
   logic [15:0] thr_q;
   logic [12:0] img_w_q;
   logic [12:0] img_h_q;
   logic [11:0] net_q;

   candidate_type pending_candidates[$];
   detection_type expected_detections[$];
   int  error_count = 0;
   int  accepted_count = 0;
   int  detection_count = 0;
   int  idle_cycles = 0;
   bit  stimulus_done;
   bit  hold_sender;
   int  send_gap;
   int  recv_gap;
   bit  req_accepted;
   bit  rsp_accepted;

   anchor_box_decode_threshold dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_scale_level  (req_item.level),
      .req_anchor_slot  (req_item.slot),
      .req_grid_col     (req_item.col),
      .req_grid_row     (req_item.row),
      .req_logit_x      (req_item.lx),
      .req_logit_y      (req_item.ly),
      .req_logit_w      (req_item.lw),
      .req_logit_h      (req_item.lh),
      .req_logit_obj    (req_item.lobj),
      .req_class_index  (req_item.cls),
      .req_logit_class  (req_item.lcls),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_class_id     (rsp_class_id),
      .rsp_score        (rsp_score),
      .rsp_left         (rsp_left),
      .rsp_top          (rsp_top),
      .rsp_right        (rsp_right),
      .rsp_bottom       (rsp_bottom),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sigmoid knots at steps of one half.
   function automatic longint knot(input int k);
      longint t[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
                        64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
                        65514};
      return t[k];
   endfunction

   // Piecewise linear sigmoid of a Q8.8 logit into Q0.16.
   function automatic longint sigmoid_q16(input logic [15:0] raw);
      longint mag;
      longint s;
      longint i;
      mag = raw[15] ? 65536 - longint'(raw) : longint'(raw);
      if (mag >= 2048) begin
         s = knot(16);
      end else begin
         i = mag >> 7;
         s = knot(int'(i)) + (((knot(int'(i) + 1) - knot(int'(i))) * (mag & 127) + 64) >> 7);
      end
      return raw[15] ? 65536 - s : s;
   endfunction

   // Truncating (pos * size) / (ns * 2^32) with a 128-bit intermediate.
   function automatic longint exact_div(input longint pos, input longint size,
                                        input longint ns);
      logic signed [127:0] num;
      logic signed [127:0] den;
      num = 128'(signed'(pos)) * 128'(signed'(size));
      den = 128'(signed'(ns)) <<< 32;
      return longint'(num / den);
   endfunction

   // Corner in Q.32 network pixels to clamped image pixels.
   function automatic logic [12:0] image_corner(input longint pos, input longint size);
      longint ns;
      longint q;
      ns = (net_q == 0) ? 1 : longint'(net_q);
      q  = exact_div(pos, size, ns);
      if (q < 0) q = 0;
      if (q > size) q = size;
      return q[12:0];
   endfunction

   // Expected detection of one candidate, if it passes the threshold.
   function automatic bit predict_detection(input candidate_type c, output detection_type d);
      longint aw[4][4] = '{'{10, 16, 33, 0}, '{30, 62, 59, 0},
                           '{116, 156, 373, 0}, '{436, 739, 925, 0}};
      longint ah[4][4] = '{'{13, 30, 23, 0}, '{61, 45, 119, 0},
                           '{90, 198, 326, 0}, '{615, 380, 1200, 0}};
      longint score;
      longint stride;
      longint sw;
      longint sh;
      longint cx;
      longint cy;
      longint hw;
      longint hh;
      d = '0;
      if (c.level >= 3 || c.slot >= 3) return 1'b0;
      score = (sigmoid_q16(c.lcls) * sigmoid_q16(c.lobj)) >> 16;
      if (score <= longint'(thr_q)) return 1'b0;
      stride = longint'(8) << c.level;
      sw = sigmoid_q16(c.lw);
      sh = sigmoid_q16(c.lh);
      cx = (2 * sigmoid_q16(c.lx) - 32768 + longint'(c.col) * 65536) * stride * 65536;
      cy = (2 * sigmoid_q16(c.ly) - 32768 + longint'(c.row) * 65536) * stride * 65536;
      hw = 2 * sw * sw * aw[c.level][c.slot];
      hh = 2 * sh * sh * ah[c.level][c.slot];
      d.cls    = c.cls;
      d.score  = score[15:0];
      d.left   = image_corner(cx - hw, img_w_q);
      d.top    = image_corner(cy - hh, img_h_q);
      d.right  = image_corner(cx + hw, img_w_q);
      d.bottom = image_corner(cy + hh, img_h_q);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d (detection %0d)", what, got, want,
               detection_count);
      error_count++;
   endtask

   // Register write at the next rising edge, mirrored in the shadow copy.
   task automatic write_csr(input abdt_csr_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      case (idx)
         CSR_SCORE_THRESHOLD: thr_q   = value;
         CSR_IMAGE_WIDTH:     img_w_q = value[12:0];
         CSR_IMAGE_HEIGHT:    img_h_q = value[12:0];
         CSR_NETWORK_SIZE:    net_q   = value[11:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait until the queue is drained and the pipeline has emptied.
   task automatic drain_pipeline();
      while (pending_candidates.size() != 0 || req_valid ||
             expected_detections.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_logit();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
         default: return 16'(int'($urandom_range(0, 2400)) - 1000);
      endcase
   endfunction

   function automatic candidate_type rand_candidate();
      candidate_type c;
      c.level = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      c.slot  = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      c.col   = 8'($urandom_range(0, 255));
      c.row   = 8'($urandom_range(0, 255));
      c.lx    = rand_logit();
      c.ly    = rand_logit();
      c.lw    = rand_logit();
      c.lh    = rand_logit();
      c.lobj  = rand_logit();
      c.cls   = 7'($urandom_range(0, 127));
      c.lcls  = rand_logit();
      return c;
   endfunction

   // Directed corner candidates: extreme logits, grid limits, all heads and slots.
   task automatic queue_directed();
      candidate_type c;
      logic [15:0] ext[4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
      for (int i = 0; i < 16; i++) begin
         c.level = 2'(i % 4);
         c.slot  = 2'((i / 4) % 4);
         c.col   = (i & 1) ? 8'd255 : 8'd0;
         c.row   = (i & 2) ? 8'd255 : 8'd0;
         c.lx    = ext[i % 4];
         c.ly    = ext[(i + 1) % 4];
         c.lw    = ext[(i + 2) % 4];
         c.lh    = ext[(i + 3) % 4];
         c.lobj  = 16'h0800 + 16'(i);
         c.cls   = (i & 1) ? 7'd127 : 7'd0;
         c.lcls  = 16'h0900;
         pending_candidates.insert(pending_candidates.size(), c);
      end
      // Logits at and next to knot boundaries, the most negative logit and zero.
      c = '0;
      c.lobj = 16'h07FF; c.lcls = 16'h0080;
      pending_candidates.insert(pending_candidates.size(), c);
      c.lobj = 16'h8000; c.lcls = 16'h8000;
      pending_candidates.insert(pending_candidates.size(), c);
      c.lobj = 16'hF800; c.lcls = 16'h0000;
      pending_candidates.insert(pending_candidates.size(), c);
      c.lobj = 16'h0000; c.lcls = 16'h0000;
      pending_candidates.insert(pending_candidates.size(), c);
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         pending_candidates.insert(pending_candidates.size(), rand_candidate());
   endtask

   // Handshakes seen at the last rising edge, for the drivers at the falling edge.
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && req_ready;
      rsp_accepted <= !reset && rsp_valid && rsp_ready;
   end

   // Request driver: one candidate at a time with a random gap before each.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (req_valid && !req_accepted) begin
         // Hold the candidate until it is taken.
      end else if (send_gap > 0) begin
         send_gap  <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (!hold_sender && pending_candidates.size() != 0) begin
         req_item  <= pending_candidates.pop_front();
         req_valid <= 1'b1;
         send_gap  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response ready with random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_accepted)
            recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      detection_type d;
      detection_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            accepted_count++;
            if (predict_detection(req_item, d))
               expected_detections.insert(expected_detections.size(), d);
         end
         if (rsp_valid && rsp_ready) begin
            detection_count++;
            if (expected_detections.size() == 0) begin
               report_mismatch("unexpected detection, class_id", rsp_class_id, -1);
            end else begin
               want = expected_detections.pop_front();
               if (rsp_class_id != want.cls)  report_mismatch("class_id", rsp_class_id, want.cls);
               if (rsp_score != want.score)   report_mismatch("score", rsp_score, want.score);
               if (rsp_left != want.left)     report_mismatch("left", rsp_left, want.left);
               if (rsp_top != want.top)       report_mismatch("top", rsp_top, want.top);
               if (rsp_right != want.right)   report_mismatch("right", rsp_right, want.right);
               if (rsp_bottom != want.bottom) report_mismatch("bottom", rsp_bottom, want.bottom);
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || stimulus_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d detections outstanding",
                  expected_detections.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus sequence over several register settings.
   initial begin
      logic [15:0] thr_set[5]  = '{16'd0, 16'd6554, 16'd30000, 16'd65535, 16'd1000};
      logic [15:0] w_set[5]    = '{16'd640, 16'd4096, 16'd1, 16'd1920, 16'd0};
      logic [15:0] h_set[5]    = '{16'd640, 16'd1, 16'd4096, 16'd1080, 16'd333};
      logic [15:0] ns_set[5]   = '{16'd640, 16'd32, 16'd2048, 16'd416, 16'd0};
      csr_write_enable = 1'b0; csr_index = CSR_SCORE_THRESHOLD; csr_write_data = '0;
      stimulus_done = 0; hold_sender = 0;
      thr_q = 16'd6554; img_w_q = 13'd640; img_h_q = 13'd640; net_q = 12'd640;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      queue_directed();
      drain_pipeline();
      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_SCORE_THRESHOLD, thr_set[p]);
         write_csr(CSR_IMAGE_WIDTH, w_set[p]);
         write_csr(CSR_IMAGE_HEIGHT, h_set[p]);
         write_csr(CSR_NETWORK_SIZE, ns_set[p]);
         queue_random(175);
         // Pause the sender midway until the pipeline has emptied.
         while (pending_candidates.size() > 90) @(posedge clock);
         hold_sender = 1;
         while (req_valid || expected_detections.size() != 0) @(posedge clock);
         hold_sender = 0;
         queue_random(175);
         drain_pipeline();
      end
      stimulus_done = 1;

      $display("Ran %0d candidates over five register settings, %0d detections checked.",
               accepted_count, detection_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
